### rtl/pft_pkg.sv
// Shared types and constants for the planar frame transform.
// Depends on nothing; every other file of the block imports it.
package pft_pkg;

	// Arctangent table, 2^32 units per full turn, one entry per iteration for up to 24 iterations
	localparam int TableLen = 24;
	localparam logic [31:0] ATAN_TAB [0:TableLen-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// CORDIC start vector, 1/K in Q2.30
	localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
	// Quarter turn in the 16-bit angle unit (2^16 per turn), half turn in the 2^32-per-turn angle unit
	localparam logic signed [15:0] QUARTER_TURN16 = 16'sd16384;
	localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;
	// Rounding bias for the Q2.30 product sum
	localparam logic signed [66:0] Q30_HALF = 67'sd536870912;
	// Saturation bounds for the Q16.16 results
	localparam logic signed [37:0] POS_MAX = 38'sd2147483647;
	localparam logic signed [37:0] POS_MIN = -38'sd2147483648;

	// Opcodes
	localparam logic OP_TO_LOCAL  = 1'b0;
	localparam logic OP_TO_GLOBAL = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] ref_x;
		logic signed [31:0] ref_y;
		logic signed [15:0] ref_theta;
		logic signed [31:0] ref_s;
		logic signed [31:0] pt_x;
		logic signed [31:0] pt_y;
		logic signed [15:0] pt_theta;
		logic signed [31:0] pt_kappa;
		logic signed [31:0] pt_s;
	} pft_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_theta;
		logic signed [31:0] out_kappa;
		logic signed [31:0] out_s;
		logic               saturated;
	} pft_out_t;

	// Fields that travel beside the CORDIC into the rotation stages
	typedef struct packed {
		logic               opcode;
		logic signed [32:0] a;      // dx for to-local, pt_x for to-global
		logic signed [32:0] b;      // dy for to-local, pt_y for to-global
		logic signed [31:0] ref_x;
		logic signed [31:0] ref_y;
		logic signed [15:0] theta;
		logic signed [31:0] kappa;
		logic signed [31:0] s;
	} pft_side_t;

endpackage

### rtl/pft_if.sv
// Valid/ready channel interfaces for the pose input and the result output.
// Depends on pft_pkg for the payload structs.
interface pft_in_if;
	logic             valid;
	logic             ready;
	pft_pkg::pft_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pft_out_if;
	logic              valid;
	logic              ready;
	pft_pkg::pft_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/planar_frame_transform.sv
// Planar frame transform top level: global/local pose change with a CORDIC pipeline.
// Depends on pft_pkg, pft_if, pft_cordic and pft_rotate.
//
//   channel    dir  handshake      payload
//   pose_in    in   valid/ready    pft_in_t  (opcode, reference pose, point pose)
//   pose_out   out  valid/ready    pft_out_t (x, y, theta, kappa, s, saturated)
//
// One beat per cycle while pose_out is not stalled; each beat passes through the input
// stage, the unrolled CORDIC (one stage per iteration), and the fold-undo, product,
// rounding and saturation stages.
// Reset clears only the valid bits; payload registers are left as they are.
// The whole pipeline holds while a result waits on pose_out, so pose_in.ready
// follows pose_out.ready whenever the output register is full.
module planar_frame_transform #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input logic     clk,
	input logic     arst_n,
	pft_in_if.sink  pose_in,
	pft_out_if.source pose_out
);
	import pft_pkg::*;

	localparam int Depth = CORDIC_ITERATIONS + 2;

	logic               adv;
	pft_side_t          side_in;
	pft_side_t          side_s [0:Depth-1];
	logic               vld_s [0:Depth-1];
	logic signed [31:0] cos_w, sin_w;
	logic               out_vld;
	pft_out_t           out_data;

	// Move everything forward unless a result is stuck at the output
	assign adv           = !out_vld || pose_out.ready;
	assign pose_in.ready = adv;

	// Form the differences or pass the point, and the heading and arc length
	always_comb begin
		side_in.opcode = pose_in.data.opcode;
		side_in.ref_x  = pose_in.data.ref_x;
		side_in.ref_y  = pose_in.data.ref_y;
		side_in.kappa  = pose_in.data.pt_kappa;
		if (pose_in.data.opcode == OP_TO_GLOBAL) begin
			side_in.a     = 33'(pose_in.data.pt_x);
			side_in.b     = 33'(pose_in.data.pt_y);
			side_in.theta = pose_in.data.ref_theta + pose_in.data.pt_theta;
			side_in.s     = pose_in.data.pt_s;
		end else begin
			side_in.a     = 33'(pose_in.data.pt_x) - 33'(pose_in.data.ref_x);
			side_in.b     = 33'(pose_in.data.pt_y) - 33'(pose_in.data.ref_y);
			side_in.theta = pose_in.data.pt_theta - pose_in.data.ref_theta;
			side_in.s     = pose_in.data.ref_s;
		end
	end

	// Sideband delay line, aligned with the CORDIC stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= pose_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k < Depth; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	pft_cordic #(
		.Iterations (CORDIC_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.adv   (adv),
		.ang   (pose_in.data.ref_theta),
		.cos_o (cos_w),
		.sin_o (sin_w)
	);

	pft_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld      (vld_s[Depth-1]),
		.side     (side_s[Depth-1]),
		.cos_i    (cos_w),
		.sin_i    (sin_w),
		.out_vld  (out_vld),
		.out_data (out_data)
	);

	assign pose_out.valid = out_vld;
	assign pose_out.data  = out_data;

endmodule

### rtl/pft_cordic.sv
// Unrolled rotation-mode CORDIC: cosine and sine of a 16-bit binary angle in Q2.30.
// Depends on pft_pkg for the arctangent table and start vector.
module pft_cordic #(
	parameter int Iterations = 16
) (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [15:0] ang,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);
	import pft_pkg::*;

	logic signed [31:0] x_s [0:Iterations];
	logic signed [31:0] y_s [0:Iterations];
	logic signed [32:0] z_s [0:Iterations];
	logic               neg_s [0:Iterations];
	logic signed [32:0] z_in;
	logic signed [31:0] cos_q, sin_q;

	// Fold the angle into the right half plane
	always_comb begin
		z_in = $signed({ang[15], ang, 16'h0000});
		if (ang > QUARTER_TURN16) begin
			z_in = z_in - HALF_TURN;
		end else if (ang < -QUARTER_TURN16) begin
			z_in = z_in + HALF_TURN;
		end
	end

	// Load the start vector with the folded angle
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]   <= CORDIC_X0;
			y_s[0]   <= '0;
			z_s[0]   <= z_in;
			neg_s[0] <= (ang > QUARTER_TURN16) || (ang < -QUARTER_TURN16);
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < Iterations; i++) begin : g_iter
		logic signed [31:0] xs, ys;
		logic signed [32:0] t;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign t  = $signed({1'b0, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_s[i][32]) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - t;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + t;
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	// Undo the fold by negating both components
	always_ff @(posedge clk) begin
		if (adv) begin
			cos_q <= neg_s[Iterations] ? -x_s[Iterations] : x_s[Iterations];
			sin_q <= neg_s[Iterations] ? -y_s[Iterations] : y_s[Iterations];
		end
	end

	assign cos_o = cos_q;
	assign sin_o = sin_q;

endmodule

### rtl/pft_rotate.sv
// Rotation, rounding, offset and saturation stages that follow the CORDIC.
// Depends on pft_pkg for the sideband and result structs and the bounds.
module pft_rotate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld,
	input  pft_pkg::pft_side_t  side,
	input  logic signed [31:0]  cos_i,
	input  logic signed [31:0]  sin_i,
	output logic                out_vld,
	output pft_pkg::pft_out_t   out_data
);
	import pft_pkg::*;

	logic               vld_s1, vld_s2, vld_s3;
	pft_side_t          side_s1, side_s2;
	logic signed [64:0] ac_s1, bs_s1, bc_s1, as_s1;
	logic signed [66:0] sum_x, sum_y;
	logic signed [36:0] rx_s2, ry_s2;
	logic signed [37:0] tx, ty;
	logic               sat_x, sat_y;
	logic signed [31:0] ox, oy;
	pft_out_t           out_s3;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: the four products
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side;
			ac_s1   <= 65'(side.a) * 65'(cos_i);
			bs_s1   <= 65'(side.b) * 65'(sin_i);
			bc_s1   <= 65'(side.b) * 65'(cos_i);
			as_s1   <= 65'(side.a) * 65'(sin_i);
		end
	end

	// Stage 2: combine the products and round back to Q16.16
	always_comb begin
		if (side_s1.opcode == OP_TO_GLOBAL) begin
			sum_x = 67'(ac_s1) - 67'(bs_s1) + Q30_HALF;
			sum_y = 67'(as_s1) + 67'(bc_s1) + Q30_HALF;
		end else begin
			sum_x = 67'(ac_s1) + 67'(bs_s1) + Q30_HALF;
			sum_y = 67'(bc_s1) - 67'(as_s1) + Q30_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			rx_s2   <= sum_x[66:30];
			ry_s2   <= sum_y[66:30];
		end
	end

	// Stage 3: add the reference position (to-global only) and clip
	always_comb begin
		tx = 38'(rx_s2);
		ty = 38'(ry_s2);
		if (side_s2.opcode == OP_TO_GLOBAL) begin
			tx = tx + 38'(side_s2.ref_x);
			ty = ty + 38'(side_s2.ref_y);
		end
		sat_x = (tx > POS_MAX) || (tx < POS_MIN);
		sat_y = (ty > POS_MAX) || (ty < POS_MIN);
		ox = (tx > POS_MAX) ? POS_MAX[31:0] : (tx < POS_MIN) ? POS_MIN[31:0] : tx[31:0];
		oy = (ty > POS_MAX) ? POS_MAX[31:0] : (ty < POS_MIN) ? POS_MIN[31:0] : ty[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s3.out_x     <= ox;
			out_s3.out_y     <= oy;
			out_s3.out_theta <= side_s2.theta;
			out_s3.out_kappa <= side_s2.kappa;
			out_s3.out_s     <= side_s2.s;
			out_s3.saturated <= sat_x | sat_y;
		end
	end

	assign out_vld  = vld_s3;
	assign out_data = out_s3;

endmodule
